>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off during reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication into the next cycle, off during reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

// implication into the next cycle, checked during reset too
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/jtag_tap_pkg.sv
// types, constants and functions of the tap shift model
package jtag_tap_pkg;

    localparam int MAX_REG_BITS   = 64;
    localparam int DATA_REG_COUNT = 3;
    localparam int LEN_W          = 7;
    localparam int SEL_W          = 2;
    localparam int CFG_DATA_W     = 7;
    localparam int CFG_INDEX_W    = 2;
    localparam int S_TDATA_W      = 8;
    localparam int M_TDATA_W      = 72;

    typedef enum logic [3:0] {
        ST_TEST_LOGIC_RESET = 4'd0,
        ST_SELECT_DR        = 4'd1,
        ST_CAPTURE_DR       = 4'd2,
        ST_SHIFT_DR         = 4'd3,
        ST_EXIT1_DR         = 4'd4,
        ST_PAUSE_DR         = 4'd5,
        ST_EXIT2_DR         = 4'd6,
        ST_UPDATE_DR        = 4'd7,
        ST_RUN_TEST_IDLE    = 4'd8,
        ST_SELECT_IR        = 4'd9,
        ST_CAPTURE_IR       = 4'd10,
        ST_SHIFT_IR         = 4'd11,
        ST_EXIT1_IR         = 4'd12,
        ST_PAUSE_IR         = 4'd13,
        ST_EXIT2_IR         = 4'd14,
        ST_UPDATE_IR        = 4'd15
    } ctrl_state_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IR_LENGTH       = 2'd0,
        CFG_DR_ONE_LENGTH   = 2'd1,
        CFG_DR_TWO_LENGTH   = 2'd2,
        CFG_DR_THREE_LENGTH = 2'd3
    } cfg_index_t;

    typedef enum logic [SEL_W-1:0] {
        SEL_BYPASS   = 2'd0,
        SEL_DR_ONE   = 2'd1,
        SEL_DR_TWO   = 2'd2,
        SEL_DR_THREE = 2'd3
    } dr_sel_t;

    typedef struct packed {
        logic [MAX_REG_BITS-1:0] register_contents;
        logic [3:0]              ctrl_state;
        logic                    tdo;
    } tap_result_t;

    function automatic ctrl_state_t tap_next(input ctrl_state_t st, input logic tms);
        ctrl_state_t nx;
        case (st)
            ST_TEST_LOGIC_RESET: nx = tms ? ST_TEST_LOGIC_RESET : ST_RUN_TEST_IDLE;
            ST_SELECT_DR:        nx = tms ? ST_SELECT_IR : ST_CAPTURE_DR;
            ST_CAPTURE_DR:       nx = tms ? ST_EXIT1_DR : ST_SHIFT_DR;
            ST_SHIFT_DR:         nx = tms ? ST_EXIT1_DR : ST_SHIFT_DR;
            ST_EXIT1_DR:         nx = tms ? ST_UPDATE_DR : ST_PAUSE_DR;
            ST_PAUSE_DR:         nx = tms ? ST_EXIT2_DR : ST_PAUSE_DR;
            ST_EXIT2_DR:         nx = tms ? ST_UPDATE_DR : ST_SHIFT_DR;
            ST_UPDATE_DR:        nx = tms ? ST_SELECT_DR : ST_RUN_TEST_IDLE;
            ST_RUN_TEST_IDLE:    nx = tms ? ST_SELECT_DR : ST_RUN_TEST_IDLE;
            ST_SELECT_IR:        nx = tms ? ST_TEST_LOGIC_RESET : ST_CAPTURE_IR;
            ST_CAPTURE_IR:       nx = tms ? ST_EXIT1_IR : ST_SHIFT_IR;
            ST_SHIFT_IR:         nx = tms ? ST_EXIT1_IR : ST_SHIFT_IR;
            ST_EXIT1_IR:         nx = tms ? ST_UPDATE_IR : ST_PAUSE_IR;
            ST_PAUSE_IR:         nx = tms ? ST_EXIT2_IR : ST_PAUSE_IR;
            ST_EXIT2_IR:         nx = tms ? ST_UPDATE_IR : ST_SHIFT_IR;
            ST_UPDATE_IR:        nx = tms ? ST_SELECT_DR : ST_RUN_TEST_IDLE;
            default:             nx = ST_TEST_LOGIC_RESET;
        endcase
        return nx;
    endfunction

    // zero counts as one bit, anything above the maximum as the maximum
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        if (len == '0) begin
            r = LEN_W'(1);
        end else if (len > LEN_W'(MAX_REG_BITS)) begin
            r = LEN_W'(MAX_REG_BITS);
        end else begin
            r = len;
        end
        return r;
    endfunction

    // len is already clamped to 1..MAX_REG_BITS
    function automatic logic [MAX_REG_BITS-1:0] shift_one(
        input logic [MAX_REG_BITS-1:0] cur,
        input logic [LEN_W-1:0]        len,
        input logic                    bit_in
    );
        logic [MAX_REG_BITS-1:0] mask;
        logic [MAX_REG_BITS-1:0] v;
        logic [LEN_W-1:0]        top;
        if (len >= LEN_W'(MAX_REG_BITS)) begin
            mask = '1;
        end else begin
            mask = (MAX_REG_BITS'(1) << len) - MAX_REG_BITS'(1);
        end
        top = len - LEN_W'(1);
        v = (cur & mask) >> 1;
        if (bit_in) begin
            v = v | (MAX_REG_BITS'(1) << top);
        end
        return v;
    endfunction

endpackage

>>> hw/rtl/jtag_tap_core.sv
// tap controller state, shift registers and per-beat step logic
module jtag_tap_core (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_wr_en,
    input  logic [jtag_tap_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [jtag_tap_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                     step_en,
    input  logic                                     tms,
    input  logic                                     tdi,
    input  logic [jtag_tap_pkg::SEL_W-1:0]           selected_dr,
    output jtag_tap_pkg::tap_result_t                result
);

    jtag_tap_pkg::ctrl_state_t                   state_reg, state_next;
    logic [jtag_tap_pkg::LEN_W-1:0]              ir_len_reg;
    logic [jtag_tap_pkg::LEN_W-1:0]              dr1_len_reg;
    logic [jtag_tap_pkg::LEN_W-1:0]              dr2_len_reg;
    logic [jtag_tap_pkg::LEN_W-1:0]              dr3_len_reg;
    logic [jtag_tap_pkg::MAX_REG_BITS-1:0]       ir_reg, ir_next;
    logic [jtag_tap_pkg::MAX_REG_BITS-1:0]       dr1_reg, dr1_next;
    logic [jtag_tap_pkg::MAX_REG_BITS-1:0]       dr2_reg, dr2_next;
    logic [jtag_tap_pkg::MAX_REG_BITS-1:0]       dr3_reg, dr3_next;

    logic                                        bypass;
    logic                                        shifting;
    logic [jtag_tap_pkg::MAX_REG_BITS-1:0]       cur;
    logic [jtag_tap_pkg::LEN_W-1:0]              len;
    logic [jtag_tap_pkg::MAX_REG_BITS-1:0]       shifted;

    // register selection
    always_comb begin
        bypass = 1'b0;
        cur    = ir_reg;
        len    = jtag_tap_pkg::clamp_len(ir_len_reg);
        if (!state_reg[3]) begin
            case (jtag_tap_pkg::dr_sel_t'(selected_dr))
                jtag_tap_pkg::SEL_DR_ONE: begin
                    cur = dr1_reg;
                    len = jtag_tap_pkg::clamp_len(dr1_len_reg);
                end
                jtag_tap_pkg::SEL_DR_TWO: begin
                    cur = dr2_reg;
                    len = jtag_tap_pkg::clamp_len(dr2_len_reg);
                end
                jtag_tap_pkg::SEL_DR_THREE: begin
                    cur = dr3_reg;
                    len = jtag_tap_pkg::clamp_len(dr3_len_reg);
                end
                default: begin
                    bypass = 1'b1;
                end
            endcase
        end
    end

    assign shifting = (state_reg == jtag_tap_pkg::ST_SHIFT_DR) ||
                      (state_reg == jtag_tap_pkg::ST_SHIFT_IR);
    assign shifted  = shifting ? jtag_tap_pkg::shift_one(cur, len, tdi) : cur;

    assign state_next = jtag_tap_pkg::tap_next(state_reg, tms);

    always_comb begin
        result.tdo               = bypass ? tdi : shifted[0];
        result.ctrl_state        = state_next;
        result.register_contents = bypass ? '0 : shifted;
    end

    // write back into the register in use
    always_comb begin
        ir_next  = ir_reg;
        dr1_next = dr1_reg;
        dr2_next = dr2_reg;
        dr3_next = dr3_reg;
        if (state_reg[3]) begin
            ir_next = shifted;
        end else begin
            case (jtag_tap_pkg::dr_sel_t'(selected_dr))
                jtag_tap_pkg::SEL_DR_ONE:   dr1_next = shifted;
                jtag_tap_pkg::SEL_DR_TWO:   dr2_next = shifted;
                jtag_tap_pkg::SEL_DR_THREE: dr3_next = shifted;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jtag_tap_pkg::ST_TEST_LOGIC_RESET;
            ir_reg    <= '0;
            dr1_reg   <= '0;
            dr2_reg   <= '0;
            dr3_reg   <= '0;
        end else if (step_en) begin
            state_reg <= state_next;
            ir_reg    <= ir_next;
            dr1_reg   <= dr1_next;
            dr2_reg   <= dr2_next;
            dr3_reg   <= dr3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ir_len_reg  <= jtag_tap_pkg::LEN_W'(4);
            dr1_len_reg <= jtag_tap_pkg::LEN_W'(32);
            dr2_len_reg <= jtag_tap_pkg::LEN_W'(32);
            dr3_len_reg <= jtag_tap_pkg::LEN_W'(32);
        end else if (cfg_wr_en) begin
            case (jtag_tap_pkg::cfg_index_t'(cfg_index))
                jtag_tap_pkg::CFG_IR_LENGTH:       ir_len_reg  <= cfg_wdata;
                jtag_tap_pkg::CFG_DR_ONE_LENGTH:   dr1_len_reg <= cfg_wdata;
                jtag_tap_pkg::CFG_DR_TWO_LENGTH:   dr2_len_reg <= cfg_wdata;
                jtag_tap_pkg::CFG_DR_THREE_LENGTH: dr3_len_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

>>> hw/rtl/jtag_tap_out_buf.sv
// result register with a skid stage behind it
module jtag_tap_out_buf (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  jtag_tap_pkg::tap_result_t     in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output jtag_tap_pkg::tap_result_t     out_data
);

    logic                          main_valid_reg, main_valid_next;
    logic                          skid_valid_reg, skid_valid_next;
    jtag_tap_pkg::tap_result_t     main_reg, main_next;
    jtag_tap_pkg::tap_result_t     skid_reg, skid_next;
    logic                          in_fire;
    logic                          main_free;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_free) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_fire;
                main_next       = in_data;
            end
        end else if (in_fire) begin
            skid_valid_next = 1'b1;
            skid_next       = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

>>> hw/rtl/jtag_tap_shift_model_unit.sv
// top level of the jtag tap shift model
//
// one input beat models one tck period of a single device: tms and tdi
// in s_tdata, the data register chosen by the instruction in s_tuser.
// every accepted beat yields exactly one result beat on the m_ side with
// the tdo level, the new controller state and the register in use.
// the step logic works between the controller state registers and the
// result register, so one beat is taken every cycle while s_tready is
// high; each result goes to m_tvalid through the result register.
// the result register has a one-beat skid stage behind it: with the
// receiver stalled the block still takes one more beat, then drops
// s_tready until the receiver takes data again.
// register lengths go in via cfg_wr_en, cfg_index, cfg_wdata; the user
// must do it only while no beat is in flight, the block does not check.
// synchronous reset puts the controller in test logic reset, clears the
// instruction and data registers, loads the default lengths and empties
// the result side.
module jtag_tap_shift_model_unit (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_wr_en,
    input  logic [jtag_tap_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [jtag_tap_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // tms, tdi, zero fill
    input  logic [jtag_tap_pkg::S_TDATA_W-1:0]        s_tdata,
    // selected_dr
    input  logic [jtag_tap_pkg::SEL_W-1:0]            s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // tdo, ctrl_state[3:0], register_contents[63:0], zero fill
    output logic [jtag_tap_pkg::M_TDATA_W-1:0]        m_tdata
);

    jtag_tap_pkg::tap_result_t step_result;
    jtag_tap_pkg::tap_result_t out_result;
    logic                      step_en;

    assign step_en = s_tvalid && s_tready;

    jtag_tap_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .step_en     (step_en),
        .tms         (s_tdata[0]),
        .tdi         (s_tdata[1]),
        .selected_dr (s_tuser),
        .result      (step_result)
    );

    jtag_tap_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (step_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {
        (jtag_tap_pkg::M_TDATA_W - $bits(jtag_tap_pkg::tap_result_t))'(0),
        out_result
    };

endmodule

>>> hw/rtl/jtag_tap_checker.sv
// port-level checks of the tap shift model, bound to the top level
`include "assert_macros.svh"

module jtag_tap_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [jtag_tap_pkg::M_TDATA_W-1:0]    m_tdata
);

    // reset empties the result side
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // input side only closes when the result register is full
    `ASSERT_IMPL(a_ready_low_full, aclk, aresetn, !s_tready, m_tvalid)

    // input side only closes after a stalled result beat
    `ASSERT_IMPL(a_ready_fall_stall, aclk, aresetn, $fell(s_tready) && $past(aresetn),
        $past(m_tvalid && !m_tready))

    // stalled result beat holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

endmodule

bind jtag_tap_shift_model_unit jtag_tap_checker u_jtag_tap_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
